>>> rtl/timer_slot_scheduler_macros.svh
// Assertion macros used by the port-level checker.
`ifndef TIMER_SLOT_SCHEDULER_MACROS_SVH
`define TIMER_SLOT_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TSS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tss_pkg.sv
// Package: sizes, operation and result codes, and the slot entry type of the timer scheduler.
package tss_pkg;
	localparam int TIMER_SLOTS = 16;
	localparam int TIME_BITS   = 32;
	localparam int MAX_RESULTS = 16;
	localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
	localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] OP_ONESHOT = 2'd0;
	localparam logic [1:0] OP_REPEAT  = 2'd1;
	localparam logic [1:0] OP_CANCEL  = 2'd2;
	localparam logic [1:0] OP_TICK    = 2'd3;

	localparam logic [1:0] KIND_SCHED = 2'd0;
	localparam logic [1:0] KIND_FIRED = 2'd1;
	localparam logic [1:0] KIND_FULL  = 2'd2;
	localparam logic [1:0] KIND_DONE  = 2'd3;

	typedef struct packed {
		logic                 repeats;
		logic [15:0]          ident;
		logic [TIME_BITS-1:0] deadline;
		logic [15:0]          period;
	} slot_entry_t;
endpackage

>>> rtl/tss_if.sv
// Valid/ready channel interfaces for the scheduler's operations and results.
interface tss_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] delay_ticks;
	logic [15:0] target_id;

	modport source (output valid, output opcode, output delay_ticks, output target_id,
		input ready);
	modport sink (input valid, input opcode, input delay_ticks, input target_id,
		output ready);
endinterface

interface tss_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] timer_id;
	logic        last;

	modport source (output valid, output kind, output timer_id, output last, input ready);
	modport sink (input valid, input kind, input timer_id, input last, output ready);
endinterface

>>> rtl/timer_slot_scheduler.sv
// Timer slot scheduler: slot entries in a synchronous memory, scanned one slot per cycle.
//
//   channel  dir  transaction
//   in_ch    in   opcode, delay_ticks, target_id
//   out_ch   out  kind, timer_id, last
//
// Work per operation before input is taken again: schedule goes straight to its result;
// cancel reads every slot, one memory read per slot; tick runs the due scan, then
// one selection pass per fired timer, since each selection pass reads every slot through the single
// memory read port, or emits the done result when nothing fired.
// Reset clears the used/live bits and time and sets the id counter to 1; the memory needs no clearing.
// A stalled result holds the block in its fire or emit step; input is taken only when idle.
module timer_slot_scheduler
	import tss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tss_in_if.sink    in_ch,
	tss_out_if.source out_ch
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIRE = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam logic [1:0] MD_CANCEL = 2'd0;
	localparam logic [1:0] MD_DUE    = 2'd1;
	localparam logic [1:0] MD_SEL    = 2'd2;

	slot_entry_t mem [TIMER_SLOTS];

	logic [1:0]             state_q;
	logic [1:0]             mode_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   rd_vld_s1;
	logic [SLOT_W-1:0]      rd_slot_s1;
	slot_entry_t            rd_data_s1;
	logic [TIMER_SLOTS-1:0] used_q, live_q, pend_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [15:0]            next_id_q;
	logic [15:0]            target_q;
	logic                   best_v_q;
	logic [SLOT_W-1:0]      best_slot_q;
	logic [TIME_BITS-1:0]   best_age_q;
	slot_entry_t            best_q;
	logic [FIRE_W-1:0]      fired_q;
	logic [1:0]             res_kind_q;
	logic [15:0]            res_id_q;
	logic                   out_valid_q;
	logic [1:0]             out_kind_q;
	logic [15:0]            out_id_q;
	logic                   out_last_q;

	logic                   out_free;
	logic                   out_load;
	logic                   has_free;
	logic [SLOT_W-1:0]      free_idx;
	logic [15:0]            sched_delay;
	logic                   mem_we, mem_re;
	logic [SLOT_W-1:0]      mem_wa;
	slot_entry_t            mem_wd;
	logic [TIME_BITS-1:0]   rd_age;
	logic                   rd_due;
	logic                   better;
	logic [TIMER_SLOTS-1:0] best_mask;
	logic                   fire_last;
	logic                   scan_more;

	assign out_free     = !out_valid_q || out_ch.ready;
	assign out_load     = out_free && (state_q == ST_FIRE || state_q == ST_EMIT);
	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.kind  = out_kind_q;
	assign out_ch.timer_id = out_id_q;
	assign out_ch.last  = out_last_q;

	always_comb begin
		free_idx = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
	end
	assign has_free = ~&used_q;

	assign sched_delay = (in_ch.opcode == OP_REPEAT && in_ch.delay_ticks == 16'd0) ?
		16'd1 : in_ch.delay_ticks;

	assign scan_more = (cnt_q < CNT_W'(TIMER_SLOTS));
	assign mem_re    = (state_q == ST_SCAN) && scan_more;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = free_idx;
		mem_wd = best_q;
		if (state_q == ST_IDLE && in_ch.valid && has_free &&
				(in_ch.opcode == OP_ONESHOT || in_ch.opcode == OP_REPEAT)) begin
			mem_we = 1'b1;
			mem_wd.repeats  = (in_ch.opcode == OP_REPEAT);
			mem_wd.ident    = next_id_q;
			mem_wd.deadline = now_q + TIME_BITS'(sched_delay);
			mem_wd.period   = sched_delay;
		end else if (state_q == ST_FIRE && out_free && best_q.repeats) begin
			mem_we = 1'b1;
			mem_wa = best_slot_q;
			mem_wd.deadline = now_q + TIME_BITS'(best_q.period);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[cnt_q[SLOT_W-1:0]];
		end
	end

	assign rd_age = now_q - rd_data_s1.deadline;
	assign rd_due = !rd_age[TIME_BITS-1];
	assign better = !best_v_q || (rd_age > best_age_q) ||
		(rd_age == best_age_q && rd_data_s1.ident < best_q.ident);
	assign best_mask = TIMER_SLOTS'(1) << best_slot_q;
	assign fire_last = ((pend_q & ~best_mask) == '0) ||
		(fired_q == FIRE_W'(MAX_RESULTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MD_CANCEL;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			used_q      <= '0;
			live_q      <= '0;
			pend_q      <= '0;
			now_q       <= '0;
			next_id_q   <= 16'd1;
			best_v_q    <= 1'b0;
			fired_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						unique case (in_ch.opcode)
							OP_ONESHOT, OP_REPEAT: begin
								if (has_free) begin
									used_q[free_idx] <= 1'b1;
									live_q[free_idx] <= 1'b1;
									next_id_q  <= (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 16'd1;
									res_kind_q <= KIND_SCHED;
									res_id_q   <= next_id_q;
								end else begin
									res_kind_q <= KIND_FULL;
									res_id_q   <= 16'd0;
								end
								state_q <= ST_EMIT;
							end
							OP_CANCEL: begin
								target_q <= in_ch.target_id;
								mode_q   <= MD_CANCEL;
								cnt_q    <= '0;
								state_q  <= ST_SCAN;
							end
							default: begin
								now_q   <= now_q + TIME_BITS'(1);
								mode_q  <= MD_DUE;
								pend_q  <= '0;
								cnt_q   <= '0;
								state_q <= ST_SCAN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_more) begin
						rd_vld_s1  <= 1'b1;
						rd_slot_s1 <= cnt_q[SLOT_W-1:0];
						cnt_q      <= cnt_q + CNT_W'(1);
					end else if (!rd_vld_s1) begin
						unique case (mode_q)
							MD_CANCEL: state_q <= ST_IDLE;
							MD_DUE: begin
								if (pend_q == '0) begin
									res_kind_q <= KIND_DONE;
									res_id_q   <= 16'd0;
									state_q    <= ST_EMIT;
								end else begin
									mode_q   <= MD_SEL;
									cnt_q    <= '0;
									best_v_q <= 1'b0;
									fired_q  <= '0;
								end
							end
							default: state_q <= ST_FIRE;
						endcase
					end
					if (rd_vld_s1) begin
						unique case (mode_q)
							MD_CANCEL: begin
								if (used_q[rd_slot_s1] && rd_data_s1.ident == target_q) begin
									live_q[rd_slot_s1] <= 1'b0;
								end
							end
							MD_DUE: begin
								if (used_q[rd_slot_s1] && rd_due) begin
									if (live_q[rd_slot_s1]) begin
										pend_q[rd_slot_s1] <= 1'b1;
									end else begin
										used_q[rd_slot_s1] <= 1'b0;
									end
								end
							end
							default: begin
								if (pend_q[rd_slot_s1] && better) begin
									best_v_q    <= 1'b1;
									best_slot_q <= rd_slot_s1;
									best_age_q  <= rd_age;
									best_q      <= rd_data_s1;
								end
							end
						endcase
					end
				end
				ST_FIRE: begin
					if (out_free) begin
						out_kind_q  <= KIND_FIRED;
						out_id_q    <= best_q.ident;
						out_last_q  <= fire_last;
						if (!best_q.repeats) begin
							used_q[best_slot_q] <= 1'b0;
							live_q[best_slot_q] <= 1'b0;
						end
						fired_q <= fired_q + FIRE_W'(1);
						if (fire_last) begin
							pend_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							pend_q[best_slot_q] <= 1'b0;
							cnt_q    <= '0;
							best_v_q <= 1'b0;
							state_q  <= ST_SCAN;
						end
					end
				end
				default: begin
					if (out_free) begin
						out_kind_q  <= res_kind_q;
						out_id_q    <= res_id_q;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end
endmodule

>>> rtl/tss_checker.sv
// Port-level checker for the timer scheduler, bound to the top level.
`include "timer_slot_scheduler_macros.svh"

module tss_checker
	import tss_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_kind,
	input logic [15:0] out_timer_id,
	input logic        out_last
);
	`TSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`TSS_ASSERT_SAME(a_zero_id, out_valid && (out_kind == KIND_FULL || out_kind == KIND_DONE), out_timer_id == 16'd0, "full or done with nonzero id")
	`TSS_ASSERT_SAME(a_real_id, out_valid && (out_kind == KIND_SCHED || out_kind == KIND_FIRED), out_timer_id != 16'd0, "id zero given out")
	`TSS_ASSERT_SAME(a_single_last, out_valid && out_kind != KIND_FIRED, out_last, "single result not marked last")
endmodule

bind timer_slot_scheduler tss_checker u_tss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_kind     (out_ch.kind),
	.out_timer_id (out_ch.timer_id),
	.out_last     (out_ch.last)
);

>>> tb/tss_tb_pkg.sv
// Package of the testbench: transaction types used by the driver and the monitor.
`timescale 1ns / 1ps
package tss_tb_pkg;
	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] delay_ticks;
		logic [15:0] target_id;
	} op_txn_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] timer_id;
		logic        last;
	} res_txn_t;
endpackage

>>> tb/tb.sv
// Testbench top: drives random and directed scheduler operations and checks every result.
`timescale 1ns / 1ps
module tb
	import tss_pkg::*, tss_tb_pkg::*;
();
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;

	tss_in_if  in_ch();
	tss_out_if out_ch();

	timer_slot_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// predictor state
	logic                 m_used    [TIMER_SLOTS];
	logic                 m_live    [TIMER_SLOTS];
	logic                 m_repeats [TIMER_SLOTS];
	logic [15:0]          m_ident   [TIMER_SLOTS];
	logic [TIME_BITS-1:0] m_deadline[TIMER_SLOTS];
	logic [15:0]          m_period  [TIMER_SLOTS];
	logic [TIME_BITS-1:0] m_now;
	logic [15:0]          m_next_id;

	op_txn_t  pending_ops[$];
	res_txn_t expected_res[$];
	int       errors;
	int       drained_hold;
	bit       rx_hold_req;

	function automatic void push_res(logic [1:0] k, logic [15:0] id, logic l);
		res_txn_t r;
		r.kind = k;
		r.timer_id = id;
		r.last = l;
		expected_res.push_back(r);
	endfunction

	function automatic void predict_op(op_txn_t t);
		int free_slot;
		int n;
		int best;
		logic [15:0] d;
		logic pend[TIMER_SLOTS];
		logic [TIME_BITS-1:0] age[TIMER_SLOTS];
		res_txn_t r;
		free_slot = -1;
		n = 0;
		if (t.opcode == OP_ONESHOT || t.opcode == OP_REPEAT) begin
			for (int i = 0; i < TIMER_SLOTS; i++)
				if (!m_used[i] && free_slot < 0) free_slot = i;
			if (free_slot < 0) begin
				push_res(KIND_FULL, 16'd0, 1'b1);
				return;
			end
			d = t.delay_ticks;
			if (t.opcode == OP_REPEAT && d == 16'd0) d = 16'd1;
			m_used[free_slot] = 1'b1;
			m_live[free_slot] = 1'b1;
			m_repeats[free_slot] = (t.opcode == OP_REPEAT);
			m_ident[free_slot] = m_next_id;
			m_period[free_slot] = d;
			m_deadline[free_slot] = m_now + TIME_BITS'(d);
			push_res(KIND_SCHED, m_next_id, 1'b1);
			m_next_id = (m_next_id == 16'hFFFF) ? 16'd1 : m_next_id + 16'd1;
		end else if (t.opcode == OP_CANCEL) begin
			for (int i = 0; i < TIMER_SLOTS; i++)
				if (m_used[i] && m_ident[i] == t.target_id) m_live[i] = 1'b0;
		end else begin
			m_now = m_now + TIME_BITS'(1);
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				pend[i] = 1'b0;
				age[i] = '0;
				if (m_used[i]) begin
					age[i] = m_now - m_deadline[i];
					if (!age[i][TIME_BITS-1]) begin
						if (m_live[i]) pend[i] = 1'b1;
						else m_used[i] = 1'b0;
					end
				end
			end
			while (n < MAX_RESULTS) begin
				best = -1;
				for (int i = 0; i < TIMER_SLOTS; i++)
					if (pend[i] && (best < 0 || age[i] > age[best] ||
							(age[i] == age[best] && m_ident[i] < m_ident[best])))
						best = i;
				if (best < 0) break;
				pend[best] = 1'b0;
				push_res(KIND_FIRED, m_ident[best], 1'b0);
				n++;
				if (m_repeats[best]) begin
					m_deadline[best] = m_now + TIME_BITS'(m_period[best]);
				end else begin
					m_used[best] = 1'b0;
					m_live[best] = 1'b0;
				end
			end
			if (n == 0) push_res(KIND_DONE, 16'd0, 1'b1);
			else begin
				r = expected_res.pop_back();
				r.last = 1'b1;
				expected_res.push_back(r);
			end
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver
	int tx_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.opcode <= OP_TICK;
			in_ch.delay_ticks <= '0;
			in_ch.target_id <= '0;
			tx_gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_op('{in_ch.opcode, in_ch.delay_ticks, in_ch.target_id});
				void'(pending_ops.pop_front());
			end
			if ((in_ch.valid && !in_ch.ready) ) begin
			end else if (tx_gap > 0) begin
				in_ch.valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (pending_ops.size() > 0) begin
				if (drained_hold == 1 &&
						(expected_res.size() != 0 || (in_ch.valid && in_ch.ready))) begin
					in_ch.valid <= 1'b0;
				end else begin
					in_ch.valid <= 1'b1;
					{in_ch.opcode, in_ch.delay_ticks, in_ch.target_id} <= pending_ops[0];
					tx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor
	int rx_gap;
	int hold_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_gap <= 0;
			hold_cnt <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_res.size() == 0) begin
					$display("%0t: unexpected result kind=%0d id=%0d last=%0d", $time,
						out_ch.kind, out_ch.timer_id, out_ch.last);
					errors++;
				end else begin
					res_txn_t e;
					e = expected_res.pop_front();
					if (e !== {out_ch.kind, out_ch.timer_id, out_ch.last}) begin
						$display("%0t: expected kind=%0d id=%0d last=%0d, got kind=%0d id=%0d last=%0d",
							$time, e.kind, e.timer_id, e.last,
							out_ch.kind, out_ch.timer_id, out_ch.last);
						errors++;
					end
				end
			end
			if (rx_hold_req && hold_cnt == 0) begin
				hold_cnt <= 3000;
				out_ch.ready <= 1'b0;
			end else if (hold_cnt > 1) begin
				hold_cnt <= hold_cnt - 1;
				out_ch.ready <= 1'b0;
			end else if (hold_cnt == 1) begin
				hold_cnt <= -1;
				out_ch.ready <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (out_ch.valid && out_ch.ready && $urandom_range(0, 2) != 0)
					rx_gap <= $urandom_range(0, 19);
			end
		end
	end

	// watchdog
	int idle_cycles;
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT + (hold_cnt > 0 ? 4000 : 0)) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic op_txn_t make_op(logic [1:0] op, logic [15:0] d, logic [15:0] id);
		op_txn_t t;
		t.opcode = op;
		t.delay_ticks = d;
		t.target_id = id;
		return t;
	endfunction

	task automatic wait_drained();
		while (pending_ops.size() != 0 || expected_res.size() != 0 ||
				in_ch.valid) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	int sel;

	initial begin
		errors = 0;
		drained_hold = 0;
		rx_hold_req = 0;
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			m_used[i] = 0; m_live[i] = 0; m_repeats[i] = 0;
			m_ident[i] = 0; m_deadline[i] = 0; m_period[i] = 0;
		end
		m_now = '0;
		m_next_id = 16'd1;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		pending_ops.push_back(make_op(OP_TICK, 16'hFFFF, 16'hFFFF));
		pending_ops.push_back(make_op(OP_ONESHOT, 16'd0, 16'h0000));
		pending_ops.push_back(make_op(OP_REPEAT, 16'd0, 16'hFFFF));
		pending_ops.push_back(make_op(OP_ONESHOT, 16'hFFFF, 16'h5A5A));
		pending_ops.push_back(make_op(OP_REPEAT, 16'd3, 16'h0));
		pending_ops.push_back(make_op(OP_CANCEL, 16'hFFFF, 16'd1234));
		pending_ops.push_back(make_op(OP_TICK, 16'd0, 16'd0));
		pending_ops.push_back(make_op(OP_ONESHOT, 16'd2, 16'd0));
		pending_ops.push_back(make_op(OP_CANCEL, 16'd0, 16'd5));
		pending_ops.push_back(make_op(OP_TICK, 16'd0, 16'd0));
		pending_ops.push_back(make_op(OP_TICK, 16'd0, 16'd0));
		pending_ops.push_back(make_op(OP_TICK, 16'd0, 16'd0));
		pending_ops.push_back(make_op(OP_CANCEL, 16'd0, 16'd2));
		pending_ops.push_back(make_op(OP_TICK, 16'd0, 16'd0));
		for (int i = 0; i < 18; i++)
			pending_ops.push_back(make_op(OP_ONESHOT, 16'd1, 16'd0));
		pending_ops.push_back(make_op(OP_TICK, 16'd0, 16'd0));
		pending_ops.push_back(make_op(OP_TICK, 16'd0, 16'd0));
		wait_drained();

		// receiver holds off while the sender keeps offering
		rx_hold_req = 1;
		for (int i = 0; i < 20; i++)
			pending_ops.push_back(make_op(OP_TICK, 16'd0, 16'd0));
		for (int i = 0; i < 8; i++)
			pending_ops.push_back(make_op(i[0] ? OP_REPEAT : OP_ONESHOT, 16'($urandom_range(0, 2)),
				16'($urandom)));
		wait_drained();

		// random
		for (int n = 0; n < 400; n++) begin
			sel = $urandom_range(0, 99);
			if (n == 200) begin
				drained_hold = 1;
				wait_drained();
				drained_hold = 0;
			end
			if (sel < 30)
				pending_ops.push_back(make_op(sel[0] ? OP_REPEAT : OP_ONESHOT,
					(sel < 25) ? 16'($urandom_range(0, 6)) : 16'($urandom), 16'($urandom)));
			else if (sel < 42)
				pending_ops.push_back(make_op(OP_CANCEL, 16'($urandom),
					(sel < 39) ? 16'($urandom_range(0, int'(m_next_id) + 1))
						: 16'($urandom)));
			else
				pending_ops.push_back(make_op(OP_TICK, 16'($urandom), 16'($urandom)));
			while (pending_ops.size() > 4) @(posedge clk);
		end
		wait_drained();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
